### src/mta_pkg.sv
// Package for the mosaic tile averager: widths, register map, divider state
// and the request/response structs between the top level and the divider.
// No dependencies.
package mta_pkg;

   localparam int MAX_WIDTH = 4096;
   localparam int MAX_TILE  = 64;

   localparam int SAMPLE_W = 8;
   localparam int MEAN_W   = 8;
   localparam int COL_W    = 12;
   localparam int DIM_W    = 13;
   localparam int TILE_W   = 7;
   localparam int OFS_W    = 6;
   localparam int SUM_W    = 20;
   localparam int AREA_W   = 13;
   localparam int CNT_W    = 5;
   localparam int ADDR_W   = 4;
   localparam int RSP_W    = 48;

   localparam logic [1:0] REG_TILE_SIZE    = 2'd0;
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

   localparam logic [TILE_W-1:0] TILE_SIZE_RST    = 7'd8;
   localparam logic [DIM_W-1:0]  IMAGE_WIDTH_RST  = 13'd640;
   localparam logic [DIM_W-1:0]  IMAGE_HEIGHT_RST = 13'd480;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_HOLD
   } div_state_type;

   typedef struct packed {
      logic              start;
      logic              take;
      logic [SUM_W-1:0]  dividend;
      logic [AREA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              valid;
      logic [MEAN_W-1:0] mean;
   } div_rsp_type;

endpackage

### src/mta_divider.sv
// Serial restoring divider for the tile mean, one quotient bit per cycle.
// Holds the mean until the result register takes it. Depends on mta_pkg.
module mta_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  mta_pkg::div_req_type req,
   output mta_pkg::div_rsp_type rsp
);

   mta_pkg::div_state_type state_ff, state_in;

   logic [mta_pkg::SUM_W-1:0]  quo_ff;
   logic [mta_pkg::AREA_W-1:0] rem_ff;
   logic [mta_pkg::AREA_W-1:0] divisor_ff;
   logic [mta_pkg::CNT_W-1:0]  cnt_ff;
   logic [mta_pkg::AREA_W:0]   trial;

   assign trial = {rem_ff, quo_ff[mta_pkg::SUM_W-1]} - {1'b0, divisor_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mta_pkg::DIV_IDLE: begin
            if (req.start) state_in = mta_pkg::DIV_RUN;
         end
         mta_pkg::DIV_RUN: begin
            if (cnt_ff == '0) state_in = mta_pkg::DIV_HOLD;
         end
         mta_pkg::DIV_HOLD: begin
            if (req.take) state_in = mta_pkg::DIV_IDLE;
         end
         default: state_in = mta_pkg::DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mta_pkg::DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == mta_pkg::DIV_IDLE && req.start) begin
         quo_ff     <= req.dividend;
         rem_ff     <= '0;
         divisor_ff <= req.divisor;
         cnt_ff     <= mta_pkg::CNT_W'(mta_pkg::SUM_W - 1);
      end else if (state_ff == mta_pkg::DIV_RUN) begin
         if (!trial[mta_pkg::AREA_W]) begin
            rem_ff <= trial[mta_pkg::AREA_W-1:0];
            quo_ff <= {quo_ff[mta_pkg::SUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[mta_pkg::AREA_W-2:0], quo_ff[mta_pkg::SUM_W-1]};
            quo_ff <= {quo_ff[mta_pkg::SUM_W-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_comb begin
      rsp.busy  = (state_ff != mta_pkg::DIV_IDLE);
      rsp.valid = (state_ff == mta_pkg::DIV_HOLD);
      rsp.mean  = (quo_ff > mta_pkg::SUM_W'(255)) ? '1 : quo_ff[mta_pkg::MEAN_W-1:0];
   end

endmodule

### src/mosaic_tile_average.sv
// Path: a tile-ending sample passes the accumulate stage, the serial divider and the result
// register before its result is offered.
// Throughput: one sample per cycle while no tile ends; a tile-ending sample holds the
// input while the serial divider works on its tile, longer only while the result
// register still holds an earlier tile. Reset: registers return to 8 / 640 / 480 and
// all positions to zero; the column-sum memory is not cleared, the first sample of
// each tile replaces it. Depends on mta_pkg and mta_divider.
module mosaic_tile_average (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] sample
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [7:0] tile_mean, [19:8] tile_column, [31:20] tile_row,
   // [38:32] tile_width, [45:39] tile_height, [47:46] zero
   output logic [mta_pkg::RSP_W-1:0]    rsp_tdata,
   output logic                         rsp_tlast,   // frame_done
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [mta_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   localparam int COL_W  = mta_pkg::COL_W;
   localparam int DIM_W  = mta_pkg::DIM_W;
   localparam int TILE_W = mta_pkg::TILE_W;
   localparam int OFS_W  = mta_pkg::OFS_W;
   localparam int SUM_W  = mta_pkg::SUM_W;

   // configuration
   logic [TILE_W-1:0] tile_size_ff;
   logic [DIM_W-1:0]  image_width_ff;
   logic [DIM_W-1:0]  image_height_ff;
   logic              cfg_write;
   logic [1:0]        cfg_index;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite;
   assign cfg_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_size_ff    <= mta_pkg::TILE_SIZE_RST;
         image_width_ff  <= mta_pkg::IMAGE_WIDTH_RST;
         image_height_ff <= mta_pkg::IMAGE_HEIGHT_RST;
      end else if (cfg_write) begin
         unique case (cfg_index)
            mta_pkg::REG_TILE_SIZE:    tile_size_ff    <= csr_pwdata[TILE_W-1:0];
            mta_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= csr_pwdata[DIM_W-1:0];
            mta_pkg::REG_IMAGE_HEIGHT: image_height_ff <= csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (cfg_index)
         mta_pkg::REG_TILE_SIZE:    csr_prdata = {25'd0, tile_size_ff};
         mta_pkg::REG_IMAGE_WIDTH:  csr_prdata = {19'd0, image_width_ff};
         mta_pkg::REG_IMAGE_HEIGHT: csr_prdata = {19'd0, image_height_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   logic restart;
   assign restart = cfg_write && (cfg_index == mta_pkg::REG_TILE_SIZE ||
                                  cfg_index == mta_pkg::REG_IMAGE_WIDTH ||
                                  cfg_index == mta_pkg::REG_IMAGE_HEIGHT);

   // clamped geometry
   logic [TILE_W-1:0] ts_eff;
   logic [DIM_W-1:0]  w_eff;
   logic [DIM_W-1:0]  h_eff;

   always_comb begin
      if (tile_size_ff == '0)                        ts_eff = TILE_W'(1);
      else if (tile_size_ff > TILE_W'(mta_pkg::MAX_TILE)) ts_eff = TILE_W'(mta_pkg::MAX_TILE);
      else                                           ts_eff = tile_size_ff;
      if (image_width_ff == '0)                      w_eff = DIM_W'(1);
      else if (image_width_ff > DIM_W'(mta_pkg::MAX_WIDTH)) w_eff = DIM_W'(mta_pkg::MAX_WIDTH);
      else                                           w_eff = image_width_ff;
      if (image_height_ff == '0)                     h_eff = DIM_W'(1);
      else if (image_height_ff > DIM_W'(mta_pkg::MAX_WIDTH)) h_eff = DIM_W'(mta_pkg::MAX_WIDTH);
      else                                           h_eff = image_height_ff;
   end

   // scan position
   logic [COL_W-1:0] col_pos_ff,  col_pos_in;
   logic [COL_W-1:0] row_pos_ff,  row_pos_in;
   logic [OFS_W-1:0] ofs_x_ff,    ofs_x_in;
   logic [OFS_W-1:0] ofs_y_ff,    ofs_y_in;
   logic [COL_W-1:0] tile_col_ff, tile_col_in;
   logic [COL_W-1:0] tile_row_ff, tile_row_in;

   logic              accept;
   logic [DIM_W-1:0]  rem_x, rem_y;
   logic [TILE_W-1:0] tw, th;
   logic [TILE_W-1:0] ofs_x_nx, ofs_y_nx;
   logic [DIM_W-1:0]  col_nx, row_nx;
   logic              emit0, first0, done0;

   always_comb begin
      rem_x    = w_eff - ({1'b0, col_pos_ff} - {7'd0, ofs_x_ff});
      rem_y    = h_eff - ({1'b0, row_pos_ff} - {7'd0, ofs_y_ff});
      tw       = (rem_x < {6'd0, ts_eff}) ? rem_x[TILE_W-1:0] : ts_eff;
      th       = (rem_y < {6'd0, ts_eff}) ? rem_y[TILE_W-1:0] : ts_eff;
      ofs_x_nx = {1'b0, ofs_x_ff} + TILE_W'(1);
      ofs_y_nx = {1'b0, ofs_y_ff} + TILE_W'(1);
      col_nx   = {1'b0, col_pos_ff} + DIM_W'(1);
      row_nx   = {1'b0, row_pos_ff} + DIM_W'(1);
      emit0    = (ofs_x_nx == tw) && (ofs_y_nx == th);
      first0   = (ofs_x_ff == '0) && (ofs_y_ff == '0);
      done0    = (col_nx == w_eff) && (row_nx == h_eff);
   end

   always_comb begin
      col_pos_in  = col_pos_ff;
      row_pos_in  = row_pos_ff;
      ofs_x_in    = ofs_x_ff;
      ofs_y_in    = ofs_y_ff;
      tile_col_in = tile_col_ff;
      tile_row_in = tile_row_ff;
      if (restart) begin
         col_pos_in  = '0;
         row_pos_in  = '0;
         ofs_x_in    = '0;
         ofs_y_in    = '0;
         tile_col_in = '0;
         tile_row_in = '0;
      end else if (accept) begin
         if (col_nx >= w_eff) begin
            col_pos_in  = '0;
            ofs_x_in    = '0;
            tile_col_in = '0;
            if (row_nx >= h_eff) begin
               row_pos_in  = '0;
               ofs_y_in    = '0;
               tile_row_in = '0;
            end else begin
               row_pos_in = row_nx[COL_W-1:0];
               if (ofs_y_nx >= th) begin
                  ofs_y_in    = '0;
                  tile_row_in = tile_row_ff + 1'b1;
               end else begin
                  ofs_y_in = ofs_y_nx[OFS_W-1:0];
               end
            end
         end else begin
            col_pos_in = col_nx[COL_W-1:0];
            if (ofs_x_nx >= ts_eff) begin
               ofs_x_in    = '0;
               tile_col_in = tile_col_ff + 1'b1;
            end else begin
               ofs_x_in = ofs_x_nx[OFS_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
         ofs_x_ff    <= '0;
         ofs_y_ff    <= '0;
         tile_col_ff <= '0;
         tile_row_ff <= '0;
      end else begin
         col_pos_ff  <= col_pos_in;
         row_pos_ff  <= row_pos_in;
         ofs_x_ff    <= ofs_x_in;
         ofs_y_ff    <= ofs_y_in;
         tile_col_ff <= tile_col_in;
         tile_row_ff <= tile_row_in;
      end
   end

   // column-sum memory and accumulate stage
   logic [SUM_W-1:0] sum_mem [mta_pkg::MAX_WIDTH];
   logic [SUM_W-1:0] rd_data_ff;

   logic              s1_valid_ff;
   logic [7:0]        s1_sample_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [COL_W-1:0]  s1_row_ff;
   logic              s1_first_ff;
   logic              s1_emit_ff;
   logic              s1_done_ff;
   logic [TILE_W-1:0] s1_tw_ff;
   logic [TILE_W-1:0] s1_th_ff;
   logic              fwd_hit_ff;
   logic [SUM_W-1:0]  fwd_sum_ff;
   logic [SUM_W-1:0]  s1_base;
   logic [SUM_W-1:0]  s1_sum;

   always_comb begin
      if (s1_first_ff)     s1_base = '0;
      else if (fwd_hit_ff) s1_base = fwd_sum_ff;
      else                 s1_base = rd_data_ff;
      s1_sum = s1_base + {12'd0, s1_sample_ff};
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= sum_mem[tile_col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         sum_mem[s1_col_ff] <= s1_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_tdata;
         s1_col_ff    <= tile_col_ff;
         s1_row_ff    <= tile_row_ff;
         s1_first_ff  <= first0;
         s1_emit_ff   <= emit0;
         s1_done_ff   <= done0;
         s1_tw_ff     <= tw;
         s1_th_ff     <= th;
         // write of the previous sample lands in the same cycle as this read
         fwd_hit_ff   <= s1_valid_ff && (s1_col_ff == tile_col_ff);
         fwd_sum_ff   <= s1_sum;
      end
   end

   // mean division and result
   mta_pkg::div_req_type div_req;
   mta_pkg::div_rsp_type div_rsp;
   logic [2*TILE_W-1:0]  area;

   logic [COL_W-1:0]  out_col_ff;
   logic [COL_W-1:0]  out_row_ff;
   logic [TILE_W-1:0] out_tw_ff;
   logic [TILE_W-1:0] out_th_ff;
   logic              out_done_ff;

   logic                      out_load;
   logic                      out_valid_ff;
   logic [mta_pkg::RSP_W-1:0] out_data_ff;
   logic                      out_last_ff;

   assign area = s1_tw_ff * s1_th_ff;

   // result register frees the divider while a result waits for its transfer
   assign out_load = div_rsp.valid && (!out_valid_ff || rsp_tready);

   always_comb begin
      div_req.start    = s1_valid_ff && s1_emit_ff;
      div_req.take     = out_load;
      div_req.dividend = s1_sum;
      div_req.divisor  = area[mta_pkg::AREA_W-1:0];
   end

   mta_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         out_col_ff  <= s1_col_ff;
         out_row_ff  <= s1_row_ff;
         out_tw_ff   <= s1_tw_ff;
         out_th_ff   <= s1_th_ff;
         out_done_ff <= s1_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= {2'b00, out_th_ff, out_tw_ff, out_row_ff, out_col_ff, div_rsp.mean};
         out_last_ff <= out_done_ff;
      end
   end

   assign req_tready = !(s1_valid_ff && s1_emit_ff) && !div_rsp.busy;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### src/mta_checker.sv
// Port-level checks for the mosaic tile averager, bound to the top level.
// Depends on mosaic_tile_average.
module mta_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a result held under backpressure stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // tile size fields always within one to the tile limit
   a_tile_dims: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[38:32] != 7'd0) && (rsp_tdata[38:32] <= 7'd64) &&
                     (rsp_tdata[45:39] != 7'd0) && (rsp_tdata[45:39] <= 7'd64))
      else $error("tile size out of range");

   // a stalled result keeps its fields
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // pad bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:46] == 2'b00)
      else $error("nonzero pad bits");

endmodule

bind mosaic_tile_average mta_checker u_mta_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
